>>> hdl/dwpsa_pkg.sv
// Shared types and constants of the dual wheel PWM step adjuster.
package dwpsa_pkg;

	// field widths
	localparam int SPD_W = 16;
	localparam int PWM_W = 10;
	localparam int ERR_W = SPD_W + 1;
	localparam int GAIN_W = 7;
	localparam int NUM_W = SPD_W + GAIN_W;
	localparam int QUO_W = PWM_W;
	localparam int DVS_W = SPD_W + QUO_W;
	localparam int ADDR_W = 5;

	// register indexes, taken from paddr[4:2]
	localparam logic [2:0] REG_SPEED_MAX = 3'd0;
	localparam logic [2:0] REG_SPEED_MIN = 3'd1;
	localparam logic [2:0] REG_PWM_FULL = 3'd2;
	localparam logic [2:0] REG_PWM_FLOOR = 3'd3;
	localparam logic [2:0] REG_PWM_BOOST = 3'd4;

	// register reset values
	localparam logic [SPD_W-1:0] RST_SPEED_MAX = 16'd2560;
	localparam logic [SPD_W-1:0] RST_SPEED_MIN = 16'd768;
	localparam logic [PWM_W-1:0] RST_PWM_FULL = 10'd1023;
	localparam logic [PWM_W-1:0] RST_PWM_FLOOR = 10'd300;
	localparam logic [PWM_W-1:0] RST_PWM_BOOST = 10'd400;

	// step gains and fixed steps
	localparam logic [GAIN_W-1:0] GAIN_INC = 7'd100;
	localparam logic [GAIN_W-1:0] GAIN_DEC = 7'd60;
	localparam logic [PWM_W-1:0] CAP_LEVEL = 10'd256;
	localparam logic [PWM_W-1:0] TURN_INC = 10'd6;
	localparam logic [PWM_W-1:0] TURN_DEC = 10'd2;
	localparam logic [PWM_W-1:0] STOP_DEC = 10'd8;

	// error thresholds, Q8.8 km/h
	localparam logic signed [ERR_W-1:0] UP_THRESH = 17'sd13;
	localparam logic signed [ERR_W-1:0] DOWN_THRESH = -17'sd26;

	// divider status toward the sequencer
	typedef struct packed {
		logic done;
		logic ovf;
		logic [QUO_W-1:0] quo;
	} div_res_t;

endpackage

>>> hdl/dwpsa_div.sv
// Serial restoring divider giving a 10-bit quotient or an overflow flag.
module dwpsa_div import dwpsa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [SPD_W-1:0] den,
	output div_res_t         res
);

	localparam logic [3:0] CNT_CHK = 4'(QUO_W);

	logic [NUM_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [QUO_W-1:0] quo_q;
	logic [3:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             ovf_q;
	logic             ge;
	logic             chk;

	// one trial subtraction per cycle
	assign ge = {{(DVS_W-NUM_W){1'b0}}, rem_q} >= dvs_q;
	assign chk = cnt_q == CNT_CHK;

	// control: first cycle checks for a quotient past 10 bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_CHK;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 4'd1;
				if ((chk && ge) || cnt_q == 4'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dvs_q <= {den, {QUO_W{1'b0}}};
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			dvs_q <= dvs_q >> 1;
			if (chk) begin
				ovf_q <= ge;
			end else begin
				quo_q <= {quo_q[QUO_W-2:0], ge};
				if (ge) begin
					rem_q <= rem_q - dvs_q[NUM_W-1:0];
				end
			end
		end
	end

	assign res = '{done: done_q, ovf: ovf_q, quo: quo_q};

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider started while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("done without a running divide");
	a_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !start && cnt_q == 4'd0) |=> (!busy_q && done_q))
		else $error("divider ran past its last step");

endmodule

>>> hdl/dual_wheel_pwm_step_adjuster.sv
// Top level: stream ports, APB registers, sequencer and wheel level update.
//
//  channel  | dir | handshake               | payload
//  s_       | in  | s_tvalid / s_tready     | tdata targets, measured; tuser pivot_turn
//  m_       | out | m_tvalid / m_tready     | tdata drive levels; tuser boost flags
//  apb      | in  | psel, penable, pready   | paddr, pwdata, prdata
//
// One request runs four step divides (inc and dec per wheel), each a load state
// plus a wait on the shared serial divider, then one update; a divide whose
// quotient passes 10 bits ends after its check step.
// Reset clears both levels to 0 and loads the register defaults.
// The result sits in an output register, so the next request is taken while it waits;
// a new result is held back only while the previous one is not yet taken.
module dual_wheel_pwm_step_adjuster import dwpsa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// target_a[15:0], target_b[31:16], measured_a[47:32], measured_b[63:48]
	input  logic [63:0]       s_tdata,
	// pivot_turn[0]
	input  logic [0:0]        s_tuser,
	output logic              m_tvalid,
	input  logic              m_tready,
	// drive_a[9:0], drive_b[19:10], zero fill[23:20]
	output logic [23:0]       m_tdata,
	// boosted_a[0], boosted_b[1]
	output logic [1:0]        m_tuser,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LOAD = 2'd1;
	localparam logic [1:0] S_WAIT = 2'd2;
	localparam logic [1:0] S_FIN = 2'd3;

	// level update of one wheel, returns {boosted, level}
	function automatic logic [PWM_W:0] wheel_upd(
		input logic [PWM_W-1:0]        lvl,
		input logic [SPD_W-1:0]        tgt,
		input logic signed [ERR_W-1:0] err,
		input logic [PWM_W-1:0]        inc,
		input logic [PWM_W-1:0]        dec,
		input logic [SPD_W-1:0]        smin,
		input logic [PWM_W-1:0]        full,
		input logic [PWM_W-1:0]        flr,
		input logic [PWM_W-1:0]        bst
	);
		logic [PWM_W-1:0]        l;
		logic signed [ERR_W-1:0] e;
		logic                    b;
		logic [PWM_W:0]          sum;
		l = lvl;
		e = err;
		b = 1'b0;
		sum = '0;
		if (l == '0 && tgt >= smin) begin
			l = bst;
			b = 1'b1;
			e = '0;
		end
		if (e >= UP_THRESH) begin
			sum = {1'b0, l} + {1'b0, inc};
			l = (sum > {1'b0, full}) ? full : sum[PWM_W-1:0];
		end
		if (e <= DOWN_THRESH) begin
			l = (l > dec) ? l - dec : '0;
		end
		if (l < flr && tgt < smin) begin
			l = '0;
		end
		return {b, l};
	endfunction

	logic [SPD_W-1:0] speed_max_q, speed_min_q;
	logic [PWM_W-1:0] pwm_full_q, pwm_floor_q, pwm_boost_q;
	logic [PWM_W-1:0] level_a_q, level_b_q;
	logic [1:0]       state_q;
	logic [1:0]       op_q;
	logic [SPD_W-1:0] ta_q, tb_q, ma_q, mb_q;
	logic             pivot_q;
	logic [PWM_W-1:0] step_q [4];
	logic             m_tvalid_q;
	logic [PWM_W-1:0] drive_a_q, drive_b_q;
	logic             boosted_a_q, boosted_b_q;

	logic                    s_fire;
	logic                    cfg_wr;
	logic                    fin_go;
	logic signed [ERR_W-1:0] err_a, err_b, err_sel;
	logic [ERR_W-1:0]        abs_sel;
	logic [SPD_W-1:0]        mag;
	logic [GAIN_W-1:0]       gain;
	logic [NUM_W-1:0]        num;
	logic [SPD_W-1:0]        den;
	logic                    div_start;
	div_res_t                div_res;
	logic [PWM_W-1:0]        step_new;
	logic [PWM_W-1:0]        inc_a, dec_a, inc_b, dec_b, lvl_a, lvl_b, top;
	logic [PWM_W:0]          upd_a, upd_b;

	assign s_fire = s_tvalid && s_tready;
	assign s_tready = state_q == S_IDLE;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_max_q <= RST_SPEED_MAX;
			speed_min_q <= RST_SPEED_MIN;
			pwm_full_q <= RST_PWM_FULL;
			pwm_floor_q <= RST_PWM_FLOOR;
			pwm_boost_q <= RST_PWM_BOOST;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_SPEED_MAX: speed_max_q <= pwdata[SPD_W-1:0];
				REG_SPEED_MIN: speed_min_q <= pwdata[SPD_W-1:0];
				REG_PWM_FULL:  pwm_full_q <= pwdata[PWM_W-1:0];
				REG_PWM_FLOOR: pwm_floor_q <= pwdata[PWM_W-1:0];
				REG_PWM_BOOST: pwm_boost_q <= pwdata[PWM_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (paddr[4:2])
			REG_SPEED_MAX: prdata = {16'b0, speed_max_q};
			REG_SPEED_MIN: prdata = {16'b0, speed_min_q};
			REG_PWM_FULL:  prdata = {22'b0, pwm_full_q};
			REG_PWM_FLOOR: prdata = {22'b0, pwm_floor_q};
			REG_PWM_BOOST: prdata = {22'b0, pwm_boost_q};
			default:       prdata = '0;
		endcase
	end

	// speed errors
	assign err_a = $signed({1'b0, ta_q}) - $signed({1'b0, ma_q});
	assign err_b = $signed({1'b0, tb_q}) - $signed({1'b0, mb_q});

	// dividend for the current step: gain times error magnitude
	assign err_sel = op_q[1] ? err_b : err_a;
	assign abs_sel = err_sel[ERR_W-1] ? ERR_W'(-err_sel) : ERR_W'(err_sel);
	assign mag = abs_sel[SPD_W-1:0];
	assign gain = op_q[0] ? GAIN_DEC : GAIN_INC;
	assign num = NUM_W'({{GAIN_W{1'b0}}, mag} * {{SPD_W{1'b0}}, gain});
	assign den = (speed_max_q == '0) ? SPD_W'(1) : speed_max_q;
	assign div_start = state_q == S_LOAD;

	dwpsa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.den    (den),
		.res    (div_res)
	);

	// a step past full scale counts as zero
	assign step_new = (div_res.ovf || div_res.quo > pwm_full_q) ? '0 : div_res.quo;

	// final level update of both wheels
	always_comb begin
		inc_a = step_q[0];
		dec_a = step_q[1];
		inc_b = step_q[2];
		dec_b = step_q[3];
		lvl_a = level_a_q;
		lvl_b = level_b_q;
		top = (level_a_q > level_b_q) ? level_a_q : level_b_q;
		if (pivot_q) begin
			inc_a = TURN_INC;
			inc_b = TURN_INC;
			dec_a = TURN_DEC;
			dec_b = TURN_DEC;
		end
		// standstill request: equalize, cap, fixed decrease
		if (ta_q == '0 && tb_q == '0) begin
			if (top > CAP_LEVEL) begin
				top = CAP_LEVEL;
			end
			lvl_a = top;
			lvl_b = top;
			dec_a = STOP_DEC;
			dec_b = STOP_DEC;
		end
		upd_a = wheel_upd(lvl_a, ta_q, err_a, inc_a, dec_a, speed_min_q,
			pwm_full_q, pwm_floor_q, pwm_boost_q);
		upd_b = wheel_upd(lvl_b, tb_q, err_b, inc_b, dec_b, speed_min_q,
			pwm_full_q, pwm_floor_q, pwm_boost_q);
	end

	assign fin_go = (state_q == S_FIN) && (!m_tvalid_q || m_tready);

	// sequencer and wheel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= '0;
			level_a_q <= '0;
			level_b_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// result valid: set by a finished update, cleared when taken
			if (fin_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_fire) begin
						op_q <= '0;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: state_q <= S_WAIT;
				S_WAIT: begin
					if (div_res.done) begin
						op_q <= op_q + 2'd1;
						state_q <= (op_q == 2'd3) ? S_FIN : S_LOAD;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						level_a_q <= upd_a[PWM_W-1:0];
						level_b_q <= upd_b[PWM_W-1:0];
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request capture, step store, result register
	always_ff @(posedge clk) begin
		if (s_fire) begin
			ta_q <= s_tdata[15:0];
			tb_q <= s_tdata[31:16];
			ma_q <= s_tdata[47:32];
			mb_q <= s_tdata[63:48];
			pivot_q <= s_tuser[0];
		end
		if (state_q == S_WAIT && div_res.done) begin
			step_q[op_q] <= step_new;
		end
		if (fin_go) begin
			drive_a_q <= upd_a[PWM_W-1:0];
			drive_b_q <= upd_b[PWM_W-1:0];
			boosted_a_q <= upd_a[PWM_W];
			boosted_b_q <= upd_b[PWM_W];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {4'b0, drive_b_q, drive_a_q};
	assign m_tuser = {boosted_b_q, boosted_a_q};

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> (state_q == S_LOAD && op_q == 2'd0))
		else $error("accepted request did not start the first step");
	a_fin_result: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> (m_tvalid_q && drive_a_q == level_a_q && drive_b_q == level_b_q))
		else $error("result does not match the stored levels");
	a_div_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> state_q == S_WAIT)
		else $error("divider finished outside the wait state");

endmodule

>>> dv/dual_wheel_pwm_step_adjuster_tb.sv
// Self-checking bench for the dual wheel PWM step adjuster: table, random phases, APB setup.
module dual_wheel_pwm_step_adjuster_tb import dwpsa_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	// step rules, Q8.8 km/h errors
	localparam int INC_GAIN = 100;
	localparam int DEC_GAIN = 60;
	localparam int RISE_MIN_ERR = 13;
	localparam int FALL_MAX_ERR = -26;
	localparam int STOP_LEVEL_CAP = 256;
	localparam int PIVOT_INC = 6;
	localparam int PIVOT_DEC = 2;
	localparam int STANDSTILL_DEC = 8;

	localparam int SETTLE_CYCLES = 60;
	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEMS_PER_PHASE = 72;
	localparam int NUM_PHASES = 6;

	typedef struct packed {
		logic [15:0] target_a;
		logic [15:0] target_b;
		logic [15:0] measured_a;
		logic [15:0] measured_b;
		logic        pivot;
	} tick_t;

	typedef struct packed {
		logic [9:0] drive_a;
		logic [9:0] drive_b;
		logic       boosted_a;
		logic       boosted_b;
	} drive_t;

	typedef struct packed {
		tick_t  stim;
		logic   typed;
		drive_t want;
	} row_t;

	typedef struct packed {
		logic [15:0] speed_max;
		logic [15:0] speed_min;
		logic [9:0]  pwm_full;
		logic [9:0]  pwm_floor;
		logic [9:0]  pwm_boost;
	} setting_t;

	// directed requests, reset register values; typed rows carry the obvious answer
	localparam row_t DIRECTED [15] = '{
		// standstill from reset
		'{'{16'd0, 16'd0, 16'd0, 16'd0, 1'b0}, 1'b1, '{10'd0, 10'd0, 1'b0, 1'b0}},
		// start boost on both wheels
		'{'{16'd768, 16'd768, 16'd0, 16'd0, 1'b0}, 1'b1, '{10'd400, 10'd400, 1'b1, 1'b1}},
		// full-range error: both steps exceed full scale and drop to zero
		'{'{16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 1'b0}, 1'b1, '{10'd400, 10'd400, 1'b0, 1'b0}},
		'{'{16'd2560, 16'd1000, 16'd0, 16'd1000, 1'b0}, 1'b0, '0},
		// pivot turn, fixed steps
		'{'{16'd1000, 16'd1000, 16'd2000, 16'd1000, 1'b1}, 1'b0, '0},
		'{'{16'd1000, 16'd1000, 16'd0, 16'd2000, 1'b1}, 1'b0, '0},
		// error right at and just inside the thresholds
		'{'{16'd1000, 16'd1000, 16'd987, 16'd1012, 1'b1}, 1'b0, '0},
		'{'{16'd1000, 16'd1000, 16'd988, 16'd1026, 1'b1}, 1'b0, '0},
		'{'{16'd1000, 16'd1000, 16'd1000, 16'd1025, 1'b1}, 1'b0, '0},
		// standstill with levels above the cap, then cut below the floor
		'{'{16'd0, 16'd0, 16'd100, 16'd100, 1'b0}, 1'b1, '{10'd0, 10'd0, 1'b0, 1'b0}},
		// target one below min: no boost, cut to zero
		'{'{16'd767, 16'd767, 16'd0, 16'd0, 1'b0}, 1'b0, '0},
		'{'{16'hFFFF, 16'd768, 16'hFFFF, 16'd0, 1'b0}, 1'b1, '{10'd400, 10'd400, 1'b1, 1'b1}},
		'{'{16'd768, 16'hFFFF, 16'hFFFF, 16'd768, 1'b0}, 1'b0, '0},
		'{'{16'd1000, 16'd900, 16'd0, 16'hFFFF, 1'b1}, 1'b0, '0},
		'{'{16'd2000, 16'd2000, 16'd1990, 16'd2050, 1'b0}, 1'b0, '0}
	};

	// fixed register phases: extremes, zero divisor and zero full scale, reset values
	localparam setting_t FIXED_PHASES [4] = '{
		'{16'd1, 16'd0, 10'd1023, 10'd0, 10'd0},
		'{16'hFFFF, 16'hFFFF, 10'd1, 10'd1023, 10'd1023},
		'{16'd0, 16'd768, 10'd0, 10'd300, 10'd400},
		'{16'd2560, 16'd768, 10'd1023, 10'd300, 10'd400}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// register mirror and wheel levels of the predictor
	int unsigned cfg_speed_max = 2560;
	int unsigned cfg_speed_min = 768;
	int unsigned cfg_pwm_full = 1023;
	int unsigned cfg_pwm_floor = 300;
	int unsigned cfg_pwm_boost = 400;
	int unsigned level_a = 0;
	int unsigned level_b = 0;

	drive_t drive_q[$];
	int mismatches = 0;
	int results_seen = 0;
	int cycles = 0;
	int burst_left = 0;

	dual_wheel_pwm_step_adjuster DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned exp_val);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_val, $realtime);
		mismatches++;
	endtask

	// step size from the error magnitude, zero when it passes full scale
	function automatic int unsigned step_size(input int err, input int unsigned gain);
		int unsigned mag;
		int unsigned div;
		int unsigned s;
		mag = (err < 0) ? -err : err;
		div = (cfg_speed_max == 0) ? 1 : cfg_speed_max;
		s = (gain * mag) / div;
		return (s > cfg_pwm_full) ? 0 : s;
	endfunction

	function automatic int unsigned next_level(input int unsigned lvl, input int unsigned target,
		input int err, input int unsigned inc, input int unsigned dec, output logic boosted);
		boosted = 1'b0;
		// stopped wheel that should run: start boost, error ignored
		if (lvl == 0 && target >= cfg_speed_min) begin
			lvl = cfg_pwm_boost;
			boosted = 1'b1;
			err = 0;
		end
		if (err >= RISE_MIN_ERR) begin
			lvl += inc;
			if (lvl > cfg_pwm_full)
				lvl = cfg_pwm_full;
		end
		if (err <= FALL_MAX_ERR)
			lvl = (lvl > dec) ? lvl - dec : 0;
		if (lvl < cfg_pwm_floor && target < cfg_speed_min)
			lvl = 0;
		return lvl & 32'h3FF;
	endfunction

	// new drive levels for one tick; advances the wheel levels
	function automatic drive_t predict_drive(input tick_t t);
		int err_a;
		int err_b;
		int unsigned inc_a, dec_a, inc_b, dec_b, top;
		logic ba, bb;
		drive_t d;
		err_a = int'(t.target_a) - int'(t.measured_a);
		err_b = int'(t.target_b) - int'(t.measured_b);
		inc_a = step_size(err_a, INC_GAIN);
		dec_a = step_size(err_a, DEC_GAIN);
		inc_b = step_size(err_b, INC_GAIN);
		dec_b = step_size(err_b, DEC_GAIN);
		if (t.pivot) begin
			inc_a = PIVOT_INC;
			inc_b = PIVOT_INC;
			dec_a = PIVOT_DEC;
			dec_b = PIVOT_DEC;
		end
		// standstill: equalize to the larger level, capped
		if (t.target_a == 0 && t.target_b == 0) begin
			top = (level_a > level_b) ? level_a : level_b;
			if (top > STOP_LEVEL_CAP)
				top = STOP_LEVEL_CAP;
			level_a = top;
			level_b = top;
			dec_a = STANDSTILL_DEC;
			dec_b = STANDSTILL_DEC;
		end
		level_a = next_level(level_a, t.target_a, err_a, inc_a, dec_a, ba);
		level_b = next_level(level_b, t.target_b, err_b, inc_b, dec_b, bb);
		d.drive_a = level_a[9:0];
		d.drive_b = level_b[9:0];
		d.boosted_a = ba;
		d.boosted_b = bb;
		return d;
	endfunction

	// APB transfer: setup, access, then idle
	task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_check(input logic [2:0] idx, input logic [31:0] exp_val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== exp_val)
			report_mismatch($sformatf("prdata reg %0d", idx), prdata, exp_val);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(input setting_t s);
		apb_write(REG_SPEED_MAX, {16'd0, s.speed_max});
		apb_write(REG_SPEED_MIN, {16'd0, s.speed_min});
		apb_write(REG_PWM_FULL, {22'd0, s.pwm_full});
		apb_write(REG_PWM_FLOOR, {22'd0, s.pwm_floor});
		apb_write(REG_PWM_BOOST, {22'd0, s.pwm_boost});
		cfg_speed_max = s.speed_max;
		cfg_speed_min = s.speed_min;
		cfg_pwm_full = s.pwm_full;
		cfg_pwm_floor = s.pwm_floor;
		cfg_pwm_boost = s.pwm_boost;
		apb_check(REG_SPEED_MAX, {16'd0, s.speed_max});
		apb_check(REG_SPEED_MIN, {16'd0, s.speed_min});
		apb_check(REG_PWM_FULL, {22'd0, s.pwm_full});
		apb_check(REG_PWM_FLOOR, {22'd0, s.pwm_floor});
		apb_check(REG_PWM_BOOST, {22'd0, s.pwm_boost});
	endtask

	// sender bursts: random gap before each burst, sometimes none
	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 :
				($urandom_range(0, 3) == 0) ? $urandom_range(1, 70) : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
	endtask

	// offer one request, predict on acceptance
	task automatic send_tick(input tick_t t, input logic typed, input drive_t want);
		drive_t d;
		s_tdata <= {t.measured_b, t.measured_a, t.target_b, t.target_a};
		s_tuser <= t.pivot;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		d = predict_drive(t);
		drive_q.push_back(typed ? want : d);
	endtask

	function automatic logic [15:0] clip_speed(input int v);
		return (v < 0) ? 16'd0 : (v > 65535) ? 16'hFFFF : v[15:0];
	endfunction

	function automatic logic [15:0] pick_target();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 65535));
			1: return clip_speed(int'(cfg_speed_min) + $urandom_range(0, 128) - 64);
			2: return 16'd0;
			default: return clip_speed($urandom_range(0, 4 * cfg_speed_min + 1000));
		endcase
	endfunction

	// measured speed mostly near the target so the thresholds get hit
	function automatic logic [15:0] pick_measured(input logic [15:0] target);
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 65535));
			1: return 16'd0;
			default: return clip_speed(int'(target) + $urandom_range(0, 160) - 80);
		endcase
	endfunction

	function automatic tick_t random_tick();
		tick_t t;
		if ($urandom_range(0, 99) < 12) begin
			t.target_a = 16'd0;
			t.target_b = 16'd0;
		end else begin
			t.target_a = pick_target();
			t.target_b = pick_target();
		end
		t.measured_a = pick_measured(t.target_a);
		t.measured_b = pick_measured(t.target_b);
		t.pivot = ($urandom_range(0, 9) < 3);
		return t;
	endfunction

	task automatic drain();
		s_tvalid <= 1'b0;
		while (drive_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// result checker
	always @(posedge clk) begin : result_check
		drive_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen <= results_seen + 1;
			if (drive_q.size() == 0) begin
				report_mismatch("unexpected result", m_tdata, 0);
			end else begin
				want = drive_q.pop_front();
				if (m_tdata[9:0] !== want.drive_a)
					report_mismatch("drive_a", m_tdata[9:0], want.drive_a);
				if (m_tdata[19:10] !== want.drive_b)
					report_mismatch("drive_b", m_tdata[19:10], want.drive_b);
				if (m_tuser[0] !== want.boosted_a)
					report_mismatch("boosted_a", m_tuser[0], want.boosted_a);
				if (m_tuser[1] !== want.boosted_b)
					report_mismatch("boosted_b", m_tuser[1], want.boosted_b);
			end
		end
	end

	// receiver stalls, with one long hold-off so the block backs up
	initial begin : result_sink
		int run_len;
		int stall_len;
		bit long_hold_done;
		long_hold_done = 0;
		wait (arst_n);
		forever begin
			run_len = $urandom_range(1, 40);
			m_tready <= 1'b1;
			repeat (run_len) @(posedge clk);
			if (!long_hold_done && results_seen >= 150) begin
				long_hold_done = 1;
				m_tready <= 1'b0;
				repeat (600) @(posedge clk);
			end else begin
				stall_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
				if (stall_len > 0) begin
					m_tready <= 1'b0;
					repeat (stall_len) @(posedge clk);
				end
			end
		end
	end

	// run time limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin : stimulus
		setting_t s;
		tick_t t;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register values after reset
		apb_check(REG_SPEED_MAX, {16'd0, 16'd2560});
		apb_check(REG_SPEED_MIN, {16'd0, 16'd768});
		apb_check(REG_PWM_FULL, {22'd0, 10'd1023});
		apb_check(REG_PWM_FLOOR, {22'd0, 10'd300});
		apb_check(REG_PWM_BOOST, {22'd0, 10'd400});

		foreach (DIRECTED[i]) begin
			pace();
			send_tick(DIRECTED[i].stim, DIRECTED[i].typed, DIRECTED[i].want);
		end
		drain();

		// fixed, then random phases; levels carry over so a lowered full scale is seen
		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p < 4) begin
				s = FIXED_PHASES[p];
			end else begin
				s.speed_max = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535)) :
					16'($urandom_range(64, 4096));
				s.speed_min = 16'($urandom_range(0, 3000));
				s.pwm_full = 10'($urandom_range(1, 1023));
				s.pwm_floor = 10'($urandom_range(0, 600));
				s.pwm_boost = 10'($urandom_range(0, 1023));
			end
			apply_setting(s);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				t = random_tick();
				pace();
				send_tick(t, 1'b0, '0);
			end
			drain();
		end

		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
